// ----- rtl/core/efmt_pkg.sv -----
// ----------------------------------------------------------------------------
// efmt_pkg
// shared constants and the crc-8 helper for the encoder frame tracker
// ----------------------------------------------------------------------------
package efmt_pkg;

  localparam int BYTE_W      = 8;
  localparam int IN_DATA_W   = 4 * BYTE_W;
  localparam int RAW_ANGLE_W = 21;
  localparam int STATUS_W    = 3;
  localparam int STARTUP_W   = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [STARTUP_W-1:0] STARTUP_LIMIT = 4'd10;

  // crc-8, poly 0x07, init 0, msb first: remainder of each single message bit,
  // index 0 is the last bit shifted in
  localparam logic [BYTE_W-1:0] CRC_COL [24] = '{
    8'h07, 8'h0E, 8'h1C, 8'h38, 8'h70, 8'hE0, 8'hC7, 8'h89,
    8'h15, 8'h2A, 8'h54, 8'hA8, 8'h57, 8'hAE, 8'h5B, 8'hB6,
    8'h6B, 8'hD6, 8'hAB, 8'h51, 8'hA2, 8'h43, 8'h86, 8'h0B
  };

  function automatic logic [BYTE_W-1:0] crc8_calc(input logic [23:0] msg);
    logic [BYTE_W-1:0] crc;
    crc = '0;
    for (int i = 0; i < 24; i++) begin
      if (msg[i]) begin
        crc = crc ^ CRC_COL[i];
      end
    end
    return crc;
  endfunction

endpackage

// ----- rtl/core/efmt_front.sv -----
// ----------------------------------------------------------------------------
// efmt_front
// frame intake: crc check, angle and status extraction, optional mirroring
// ----------------------------------------------------------------------------
module efmt_front #(
  parameter int ANGLE_BITS = 21
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [efmt_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                             q_full,
  output logic                             q_wr_en,
  output logic [ANGLE_BITS+efmt_pkg::STATUS_W:0] q_wr_data
);
  import efmt_pkg::*;

  logic                   reverse_direction;
  logic [BYTE_W-1:0]      b0;
  logic [BYTE_W-1:0]      b1;
  logic [BYTE_W-1:0]      b2;
  logic [BYTE_W-1:0]      rx_crc;
  logic                   crc_ok;
  logic [RAW_ANGLE_W-1:0] raw_angle;
  logic [ANGLE_BITS-1:0]  angle;
  logic [ANGLE_BITS-1:0]  angle_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_direction <= 1'b0;
    end else if (cfg_we) begin
      reverse_direction <= cfg_wdata;
    end
  end

  assign b0     = s_tdata[BYTE_W-1:0];
  assign b1     = s_tdata[2*BYTE_W-1:BYTE_W];
  assign b2     = s_tdata[3*BYTE_W-1:2*BYTE_W];
  assign rx_crc = s_tdata[4*BYTE_W-1:3*BYTE_W];

  assign crc_ok    = (crc8_calc({b0, b1, b2}) == rx_crc);
  assign raw_angle = {b0, b1, b2[BYTE_W-1:STATUS_W]};
  assign angle     = ANGLE_BITS'(raw_angle);
  // two's complement negate keeps zero at zero
  assign angle_m   = reverse_direction ? (~angle + 1'b1) : angle;

  assign s_tready  = !q_full;
  assign q_wr_en   = s_tvalid && !q_full;
  assign q_wr_data = {crc_ok, b2[STATUS_W-1:0], angle_m};

endmodule

// ----- rtl/core/efmt_queue.sv -----
// ----------------------------------------------------------------------------
// efmt_queue
// small fifo between frame intake and the unwrap stage
// ----------------------------------------------------------------------------
module efmt_queue #(
  parameter int WIDTH = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);
  import efmt_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_rd;

  assign full     = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !do_rd) begin
        count <= count + 1'b1;
      end else if (!wr_en && do_rd) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/efmt_back.sv -----
// ----------------------------------------------------------------------------
// efmt_back
// multiturn unwrap, saturating rotation count and registered result
// ----------------------------------------------------------------------------
module efmt_back #(
  parameter int ANGLE_BITS    = 21,
  parameter int ROTATION_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  input  logic [ANGLE_BITS+efmt_pkg::STATUS_W:0] q_data,
  output logic                                   q_rd_en,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [ANGLE_BITS-1:0]                  angle_count,
  output logic signed [ROTATION_BITS-1:0]        rotation_count,
  output logic signed [ANGLE_BITS:0]             angle_delta,
  output logic [efmt_pkg::STATUS_W-1:0]          sensor_status,
  output logic                                   crc_mismatch,
  output logic                                   speed_valid
);
  import efmt_pkg::*;

  localparam logic signed [ANGLE_BITS:0] CPR      = {1'b1, {ANGLE_BITS{1'b0}}};
  localparam logic signed [ANGLE_BITS:0] HALF     = {2'b01, {(ANGLE_BITS-1){1'b0}}};
  localparam logic signed [ANGLE_BITS:0] NEG_HALF = -HALF;
  localparam logic signed [ROTATION_BITS-1:0] ROT_MAX = {1'b0, {(ROTATION_BITS-1){1'b1}}};
  localparam logic signed [ROTATION_BITS-1:0] ROT_MIN = {1'b1, {(ROTATION_BITS-1){1'b0}}};

  logic                            seeded;
  logic [ANGLE_BITS-1:0]           last_angle;
  logic [ANGLE_BITS-1:0]           current_angle;
  logic signed [ROTATION_BITS-1:0] rotations;
  logic [STARTUP_W-1:0]            startup_count;
  logic [STATUS_W-1:0]             status_hold;

  logic                            item_ok;
  logic [STATUS_W-1:0]             item_status;
  logic [ANGLE_BITS-1:0]           item_angle;

  logic                            seeded_next;
  logic [ANGLE_BITS-1:0]           last_angle_next;
  logic [ANGLE_BITS-1:0]           current_angle_next;
  logic signed [ROTATION_BITS-1:0] rotations_next;
  logic [STARTUP_W-1:0]            startup_count_next;
  logic [STATUS_W-1:0]             status_hold_next;
  logic signed [ANGLE_BITS:0]      diff;
  logic signed [ANGLE_BITS:0]      delta_next;
  logic                            speed_next;

  assign item_angle  = q_data[ANGLE_BITS-1:0];
  assign item_status = q_data[ANGLE_BITS+STATUS_W-1:ANGLE_BITS];
  assign item_ok     = q_data[ANGLE_BITS+STATUS_W];

  assign q_rd_en = q_valid && (!m_tvalid || m_tready);

  always_comb begin
    current_angle_next = item_ok ? item_angle : current_angle;
    status_hold_next   = item_ok ? item_status : status_hold;
    seeded_next        = seeded;
    last_angle_next    = last_angle;
    rotations_next     = rotations;
    startup_count_next = startup_count;
    diff               = $signed({1'b0, current_angle_next}) - $signed({1'b0, last_angle});
    delta_next         = '0;
    speed_next         = 1'b0;
    if (!seeded) begin
      if (item_ok) begin
        last_angle_next = current_angle_next;
        seeded_next     = 1'b1;
      end
    end else begin
      last_angle_next = current_angle_next;
      delta_next      = diff;
      if (diff > HALF) begin
        if (rotations != ROT_MIN) begin
          rotations_next = rotations - 1'b1;
        end
        delta_next = diff - CPR;
      end else if (diff < NEG_HALF) begin
        if (rotations != ROT_MAX) begin
          rotations_next = rotations + 1'b1;
        end
        delta_next = diff + CPR;
      end
      if (startup_count <= STARTUP_LIMIT) begin
        startup_count_next = startup_count + 1'b1;
      end else begin
        speed_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded        <= 1'b0;
      last_angle    <= '0;
      current_angle <= '0;
      rotations     <= '0;
      startup_count <= '0;
      status_hold   <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      m_tvalid <= q_rd_en || (m_tvalid && !m_tready);
      if (q_rd_en) begin
        seeded        <= seeded_next;
        last_angle    <= last_angle_next;
        current_angle <= current_angle_next;
        rotations     <= rotations_next;
        startup_count <= startup_count_next;
        status_hold   <= status_hold_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd_en) begin
      angle_count    <= current_angle_next;
      rotation_count <= rotations_next;
      angle_delta    <= delta_next;
      sensor_status  <= status_hold_next;
      crc_mismatch   <= !item_ok;
      speed_valid    <= speed_next;
    end
  end

  // unseeded frames carry no motion
  a_unseeded_quiet: assert property (@(posedge clk) disable iff (rst)
    (q_rd_en && !seeded) |=> (angle_delta == '0 && !speed_valid))
    else $error("unseeded frame produced delta or speed flag");

  // a failed frame never moves the held angle
  a_crc_fail_holds: assert property (@(posedge clk) disable iff (rst)
    (q_rd_en && !item_ok) |=> (current_angle == $past(current_angle)))
    else $error("angle changed on crc failure");

  a_startup_bound: assert property (@(posedge clk) disable iff (rst)
    startup_count <= STARTUP_LIMIT + 1'b1)
    else $error("startup counter overran");

  a_speed_after_startup: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && speed_valid) |-> (startup_count == STARTUP_LIMIT + 1'b1))
    else $error("speed flagged before startup completed");

endmodule

// ----- rtl/core/encoder_frame_multiturn_tracker.sv -----
// ----------------------------------------------------------------------------
// encoder_frame_multiturn_tracker
// absolute encoder burst frame checker with multiturn angle unwrap
// ----------------------------------------------------------------------------
// usage
//   s_* channel takes one burst frame per transfer: s_tdata holds the high,
//   mid and low/status angle bytes and the received crc byte, lowest first.
//   m_* channel gives one result per frame: angle, rotation count, unwrapped
//   delta and status in m_tdata; crc error and speed valid flags in m_tuser.
//   cfg_we/cfg_wdata set the reverse direction bit; write only while idle.
// result path and throughput
//   an accepted frame is written into the intake queue and then into the
//   result register before it is shown on m_*.
//   one frame per cycle is sustained while m_tready stays high; the unwrap
//   stage retires one frame per cycle from a two-entry queue when not stalled.
// reset and stall
//   rst clears the queue, the angle, rotation and startup state and the
//   reverse bit. while m_tready is low the result holds, the queue absorbs
//   two more frames and then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module encoder_frame_multiturn_tracker #(
  parameter int ANGLE_BITS    = 21,
  parameter int ROTATION_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic                                  cfg_wdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // angle_high_byte, angle_mid_byte, angle_low_status_byte, frame_crc
  input  logic [efmt_pkg::IN_DATA_W-1:0]        s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // angle_count, rotation_count, angle_delta, sensor_status, zero fill
  output logic [((2*ANGLE_BITS+ROTATION_BITS+efmt_pkg::STATUS_W+1+7)/8)*8-1:0] m_tdata,
  // crc_mismatch, speed_valid
  output logic [1:0]                            m_tuser
);
  import efmt_pkg::*;

  localparam int Q_W        = ANGLE_BITS + STATUS_W + 1;
  localparam int OUT_FLD_W  = 2*ANGLE_BITS + ROTATION_BITS + STATUS_W + 1;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  logic                            q_wr_en;
  logic [Q_W-1:0]                  q_wr_data;
  logic                            q_full;
  logic                            q_rd_en;
  logic                            q_valid;
  logic [Q_W-1:0]                  q_data;
  logic [ANGLE_BITS-1:0]           angle_count;
  logic signed [ROTATION_BITS-1:0] rotation_count;
  logic signed [ANGLE_BITS:0]      angle_delta;
  logic [STATUS_W-1:0]             sensor_status;
  logic                            crc_mismatch;
  logic                            speed_valid;

  efmt_front #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_wr_en  (q_wr_en),
    .q_wr_data(q_wr_data)
  );

  efmt_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd_en),
    .rd_valid(q_valid),
    .rd_data (q_data)
  );

  efmt_back #(
    .ANGLE_BITS   (ANGLE_BITS),
    .ROTATION_BITS(ROTATION_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_rd_en       (q_rd_en),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .angle_count   (angle_count),
    .rotation_count(rotation_count),
    .angle_delta   (angle_delta),
    .sensor_status (sensor_status),
    .crc_mismatch  (crc_mismatch),
    .speed_valid   (speed_valid)
  );

  assign m_tdata = OUT_DATA_W'({sensor_status, angle_delta, rotation_count, angle_count});
  assign m_tuser = {speed_valid, crc_mismatch};

endmodule

// ----- dv/tracker_checker.sv -----
// ----------------------------------------------------------------------------
// tracker_checker
// watches the frame and result streams of the encoder multiturn tracker,
// predicts each result and compares it field by field, in order
// ----------------------------------------------------------------------------
package tracker_tb_pkg;

  localparam int ANG_W   = 21;
  localparam int ROT_W   = 32;
  localparam int OUT_W   = ((2 * ANG_W + ROT_W + efmt_pkg::STATUS_W + 1 + 7) / 8) * 8;
  localparam int FILL_LO = 2 * ANG_W + ROT_W + 1 + efmt_pkg::STATUS_W;

  localparam logic [7:0]       CRC_POLY  = 8'h07;
  localparam logic [ANG_W-1:0] HALF_TURN = {1'b1, {(ANG_W - 1){1'b0}}};

  // crc-8 over three bytes, high byte first, msb first
  function automatic logic [7:0] burst_crc8(input logic [23:0] msg);
    logic [7:0] crc;
    logic       fb;
    crc = '0;
    for (int i = 23; i >= 0; i--) begin
      fb  = crc[7] ^ msg[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return crc;
  endfunction

endpackage

module tracker_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_wdata,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [efmt_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [tracker_tb_pkg::OUT_W-1:0] m_tdata,
  input  logic [1:0]                       m_tuser,
  output int                               mismatches,
  output int                               outstanding,
  output int                               checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import tracker_tb_pkg::*;

  localparam logic signed [ROT_W-1:0] TURNS_MAX = {1'b0, {(ROT_W - 1){1'b1}}};
  localparam logic signed [ROT_W-1:0] TURNS_MIN = {1'b1, {(ROT_W - 1){1'b0}}};

  typedef struct packed {
    logic [ANG_W-1:0]        angle;
    logic signed [ROT_W-1:0] turns;
    logic signed [ANG_W:0]   delta;
    logic [2:0]              status;
    logic                    crc_err;
    logic                    spd_ok;
  } tracker_out_t;

  tracker_out_t            expected_q[$];
  logic                    reverse;
  logic [ANG_W-1:0]        prev_angle;
  logic [ANG_W-1:0]        cur_angle;
  logic signed [ROT_W-1:0] turns;
  int unsigned             warmup;
  logic [2:0]              status_hold;
  logic                    seeded;
  int                      err_count = 0;
  int                      done_count = 0;

  function automatic tracker_out_t track_frame(input logic [31:0] frame);
    logic [7:0]       hi, mid, lo, rx;
    logic             ok;
    logic [ANG_W-1:0] a;
    longint           d, cpr, half;
    tracker_out_t     r;
    hi   = frame[7:0];
    mid  = frame[15:8];
    lo   = frame[23:16];
    rx   = frame[31:24];
    ok   = (burst_crc8({hi, mid, lo}) == rx);
    cpr  = longint'(1) << ANG_W;
    half = cpr / 2;
    d    = 0;
    r.spd_ok = 1'b0;
    if (ok) begin
      a = {hi, mid, lo[7:3]};
      // mirror wraps within the angle width, so zero stays zero
      if (reverse) begin
        a = -a;
      end
      cur_angle   = a;
      status_hold = lo[2:0];
    end
    if (!seeded) begin
      if (ok) begin
        prev_angle = cur_angle;
        seeded     = 1'b1;
      end
    end else begin
      d          = longint'(cur_angle) - longint'(prev_angle);
      prev_angle = cur_angle;
      if (d > half) begin
        if (turns != TURNS_MIN) begin
          turns = turns - 1;
        end
        d = d - cpr;
      end else if (d < -half) begin
        if (turns != TURNS_MAX) begin
          turns = turns + 1;
        end
        d = d + cpr;
      end
      if (warmup <= efmt_pkg::STARTUP_LIMIT) begin
        warmup++;
      end else begin
        r.spd_ok = 1'b1;
      end
    end
    r.angle   = cur_angle;
    r.turns   = turns;
    r.delta   = d[ANG_W:0];
    r.status  = status_hold;
    r.crc_err = !ok;
    return r;
  endfunction

  function automatic void compare_field(input string name, input longint want,
                                        input longint seen);
    if (want != seen) begin
      if (err_count < 10) begin
        $display("mismatch in %s at result %0d: expected %0d, got %0d",
                 name, done_count, want, seen);
      end
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    tracker_out_t             want;
    tracker_out_t             seen;
    logic [OUT_W-FILL_LO-1:0] fill;
    if (rst) begin
      expected_q.delete();
      reverse     = 1'b0;
      prev_angle  = '0;
      cur_angle   = '0;
      turns       = '0;
      warmup      = 0;
      status_hold = '0;
      seeded      = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen.angle   = m_tdata[ANG_W-1:0];
        seen.turns   = m_tdata[ANG_W +: ROT_W];
        seen.delta   = m_tdata[ANG_W+ROT_W +: ANG_W+1];
        seen.status  = m_tdata[2*ANG_W+ROT_W+1 +: 3];
        seen.crc_err = m_tuser[0];
        seen.spd_ok  = m_tuser[1];
        fill         = m_tdata[OUT_W-1:FILL_LO];
        if (expected_q.size() == 0) begin
          if (err_count < 10) begin
            $display("unexpected result transfer, angle %0d", seen.angle);
          end
          err_count++;
        end else begin
          want = expected_q.pop_front();
          compare_field("angle_count", want.angle, seen.angle);
          compare_field("rotation_count", longint'($signed(want.turns)),
                        longint'($signed(seen.turns)));
          compare_field("angle_delta", longint'($signed(want.delta)),
                        longint'($signed(seen.delta)));
          compare_field("sensor_status", want.status, seen.status);
          compare_field("crc_mismatch", want.crc_err, seen.crc_err);
          compare_field("speed_valid", want.spd_ok, seen.spd_ok);
          compare_field("zero fill", 0, fill);
          done_count++;
        end
      end
      if (cfg_we) begin
        reverse = cfg_wdata;
      end
      if (s_tvalid && s_tready) begin
        expected_q.push_back(track_frame(s_tdata));
      end
    end
    mismatches  <= err_count;
    outstanding <= expected_q.size();
    checked     <= done_count;
  end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives burst frames into the encoder multiturn tracker: directed seeding,
// wrap, half-turn, mirror and crc failure cases, then random angle walks
// with bad and garbage frames under three sender/receiver stall mixes
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tracker_tb_pkg::*;

  localparam int HOLD_LEN    = 300;
  localparam int QUIET_LIMIT = 3000;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic                           cfg_wdata = 1'b0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [efmt_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [OUT_W-1:0]               m_tdata;
  logic [1:0]                     m_tuser;

  int               send_idle = 0;
  int               recv_idle = 0;
  bit               hold_go = 1'b0;
  bit               hold_done = 1'b0;
  int               frames_sent = 0;
  int               bad_sent = 0;
  int               quiet = 0;
  logic [ANG_W-1:0] walk = '0;
  int               mismatches;
  int               outstanding;
  int               checked;

  always #5 clk = ~clk;

  encoder_frame_multiturn_tracker #(
    .ANGLE_BITS    (ANG_W),
    .ROTATION_BITS (ROT_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  tracker_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  function automatic logic [31:0] pack_frame(input logic [ANG_W-1:0] ang,
                                             input logic [2:0] st, input bit corrupt);
    logic [23:0] body;
    logic [7:0]  crc;
    body = {ang, st};
    crc  = burst_crc8(body);
    if (corrupt) begin
      crc = crc ^ 8'($urandom_range(255, 1));
    end
    return {crc, body[7:0], body[15:8], body[23:16]};
  endfunction

  // mostly well-formed steps of the angle walk, some bad crc and raw noise
  function automatic logic [31:0] next_frame();
    int               r;
    logic [ANG_W-1:0] step;
    logic [2:0]       st;
    r  = $urandom_range(99);
    st = 3'($urandom_range(7));
    if (r < 45) begin
      step = ANG_W'($urandom_range(2048));
    end else if (r < 62) begin
      step = ANG_W'(HALF_TURN - 2000 + $urandom_range(4000));
    end else if (r < 67) begin
      step = HALF_TURN;
    end else if (r < 77) begin
      walk = ANG_W'($urandom);
      step = '0;
    end else if (r < 83) begin
      walk = $urandom_range(1) ? '0 : '1;
      step = '0;
    end else if (r < 92) begin
      return pack_frame(walk + ANG_W'($urandom), st, 1'b1);
    end else begin
      return $urandom;
    end
    if ($urandom_range(1)) begin
      walk = walk + step;
    end else begin
      walk = walk - step;
    end
    return pack_frame(walk, st, 1'b0);
  endfunction

  task automatic send_frame(input logic [31:0] frame);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= frame;
    do @(posedge clk); while (!s_tready);
    frames_sent++;
    if (burst_crc8({frame[7:0], frame[15:8], frame[23:16]}) != frame[31:24]) begin
      bad_sent++;
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reverse(input logic rev);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= rev;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        for (int i = 0; i < HOLD_LEN; i++) begin
          m_tready <= 1'b0;
          @(posedge clk);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet);
      $display("testbench: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= 1'b0;
    @(posedge clk);
    cfg_we    <= 1'b0;

    // seeding, wraps, half turn both ways, crc failures, byte extremes
    send_frame(pack_frame(21'h12345, 3'd2, 1'b1));
    send_frame(pack_frame('0, 3'd0, 1'b0));
    send_frame(pack_frame('1, 3'd7, 1'b0));
    send_frame(pack_frame('0, 3'd5, 1'b0));
    send_frame(pack_frame(HALF_TURN, 3'd1, 1'b0));
    send_frame(pack_frame('0, 3'd6, 1'b0));
    send_frame(pack_frame(HALF_TURN + 1'b1, 3'd3, 1'b0));
    send_frame(pack_frame(HALF_TURN + 1'b1, 3'd4, 1'b1));
    send_frame(32'h0000_0000);
    send_frame(32'hFF00_0000);
    send_frame(32'hFFFF_FFFF);
    send_frame(pack_frame('1, 3'd7, 1'b0));
    send_frame(pack_frame(21'h155555, 3'd5, 1'b0));
    send_frame(pack_frame(21'h0AAAAA, 3'd2, 1'b0));

    // mirrored direction, zero must stay zero
    write_reverse(1'b1);
    send_frame(pack_frame('0, 3'd0, 1'b0));
    send_frame(pack_frame(21'd1, 3'd1, 1'b0));
    send_frame(pack_frame('1, 3'd7, 1'b0));
    send_frame(pack_frame(HALF_TURN, 3'd2, 1'b0));
    send_frame(pack_frame(21'h0AAAAA, 3'd3, 1'b1));

    send_idle = 36;
    recv_idle = 74;
    repeat (700) send_frame(next_frame());

    write_reverse(1'b0);
    send_idle = 74;
    recv_idle = 36;
    repeat (700) send_frame(next_frame());

    write_reverse(1'b1);
    send_idle = 0;
    recv_idle = 0;
    hold_go   = 1'b1;
    repeat (600) send_frame(next_frame());

    drain_results();
    repeat (10) @(posedge clk);
    $display("covered %0d frames (%0d failing crc), %0d results checked",
             frames_sent, bad_sent, checked);
    $display("reverse off and on, three stall mixes, one %0d-cycle output hold", HOLD_LEN);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
